FILE: rtl/ps16s_pkg.sv
// Package for the posit16 sin(pi*x) pipeline: constants of the fixed-point
// datapath and the leading-zero count helpers. No dependencies.
package ps16s_pkg;

	localparam logic [15:0] NAR_CODE    = 16'h8000;
	localparam logic [15:0] MAG_MAX     = 16'd31743;
	localparam logic [27:0] HALF_PERIOD = 28'h800_0000;
	localparam logic [26:0] LIN_LIMIT   = 27'h00A_5801;
	localparam logic [16:0] LIN_SLOPE   = 17'd102943;
	localparam logic [9:0]  POLY_C1     = 10'd650;
	localparam logic [13:0] POLY_C2     = 14'd9813;
	localparam logic [18:0] POLY_C3     = 19'd334253;
	localparam logic [22:0] POLY_C4     = 23'd5418741;
	localparam logic [25:0] POLY_C5     = 26'd52707180;
	localparam logic [27:0] CORE_MAX    = 28'hFFF_FFFF;
	localparam logic [14:0] ONE_CODE    = 15'h4000;

	function automatic logic [3:0] lzc14(input logic [13:0] v);
		logic [3:0] n;
		logic       hit;
		n   = 4'd14;
		hit = 1'b0;
		for (int i = 13; i >= 0; i--) begin
			if (!hit && v[i]) begin
				n   = 4'(13 - i);
				hit = 1'b1;
			end
		end
		return n;
	endfunction

	function automatic logic [4:0] lzc28(input logic [27:0] v);
		logic [4:0] n;
		logic       hit;
		n   = 5'd27;
		hit = 1'b0;
		for (int i = 27; i >= 0; i--) begin
			if (!hit && v[i]) begin
				n   = 5'(27 - i);
				hit = 1'b1;
			end
		end
		return n;
	endfunction

endpackage

FILE: rtl/ps16s_if.sv
// Valid/ready channels for the posit16 sin(pi*x) pipeline: the argument
// channel and the result channel. No dependencies.
interface ps16s_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] posit_in;

	modport source (output valid, output posit_in, input ready);
	modport sink   (input valid, input posit_in, output ready);
endinterface

interface ps16s_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] posit_out;

	modport source (output valid, output posit_out, input ready);
	modport sink   (input valid, input posit_out, output ready);
endinterface

FILE: rtl/posit16_sinpi_fixed_point.sv
// Posit16 (es=1) sin(pi*x) as an 11-stage pipeline; uses ps16s_pkg and ps16s_if.
// Throughput one item per cycle while res.ready is high; a low res.ready stalls the pipeline.
// Depth is set by the Horner chain: six dependent multiplies, one stage each,
// between decode/range reduction and normalize/round.
// Each stage stalls only when it and all later stages hold items; bubbles close up.
// Reset clears the stage valid bits only; the datapath is not reset.
module posit16_sinpi_fixed_point
	import ps16s_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	ps16s_in_if.sink           arg,
	ps16s_out_if.source        res
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8, en_s9, en_s10, en_s11;

	assign en_s11 = !v_s11 || res.ready;
	assign en_s10 = !v_s10 || en_s11;
	assign en_s9  = !v_s9  || en_s10;
	assign en_s8  = !v_s8  || en_s9;
	assign en_s7  = !v_s7  || en_s8;
	assign en_s6  = !v_s6  || en_s7;
	assign en_s5  = !v_s5  || en_s6;
	assign en_s4  = !v_s4  || en_s5;
	assign en_s3  = !v_s3  || en_s4;
	assign en_s2  = !v_s2  || en_s3;
	assign en_s1  = !v_s1  || en_s2;
	assign arg.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else begin
			if (en_s1)  v_s1  <= arg.valid;
			if (en_s2)  v_s2  <= v_s1;
			if (en_s3)  v_s3  <= v_s2;
			if (en_s4)  v_s4  <= v_s3;
			if (en_s5)  v_s5  <= v_s4;
			if (en_s6)  v_s6  <= v_s5;
			if (en_s7)  v_s7  <= v_s6;
			if (en_s8)  v_s8  <= v_s7;
			if (en_s9)  v_s9  <= v_s8;
			if (en_s10) v_s10 <= v_s9;
			if (en_s11) v_s11 <= v_s10;
		end
	end

	// stage 1: magnitude, special cases, regime decode
	logic [15:0] mag;
	logic [13:0] run_bits;
	logic [3:0]  run_len;
	logic [13:0] mag_sh;
	logic [5:0]  shamt;
	logic        neg_s1, spec_s1;
	logic [15:0] sval_s1;
	logic [12:0] frac_s1;
	logic [5:0]  sh_s1;

	always_comb begin
		mag      = arg.posit_in[15] ? 16'(17'h1_0000 - {1'b0, arg.posit_in}) : arg.posit_in;
		run_bits = mag[14] ? ~mag[13:0] : mag[13:0];
		run_len  = lzc14(run_bits);
		mag_sh   = mag[13:0] << run_len;
		shamt    = mag[14] ? 6'(6'd28 + {1'b0, run_len, 1'b0} + {5'b0, mag_sh[12]})
		                   : 6'(6'd26 - {1'b0, run_len, 1'b0} + {5'b0, mag_sh[12]});
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			neg_s1  <= arg.posit_in[15];
			spec_s1 <= (mag > MAG_MAX) || (mag == 16'd0);
			sval_s1 <= (mag == NAR_CODE) ? NAR_CODE : 16'd0;
			frac_s1 <= {1'b1, mag_sh[11:0]};
			sh_s1   <= shamt;
		end
	end

	// stage 2: fixed-point value, quadrant split, mirror
	logic [40:0] wide;
	logic [1:0]  quad;
	logic [26:0] rem;
	logic        neg2;
	logic        neg_s2, spec_s2;
	logic [15:0] sval_s2;
	logic [26:0] r_s2;

	always_comb begin
		wide = {28'd0, frac_s1} << sh_s1;
		quad = wide[40:39];
		rem  = wide[38:12];
		neg2 = neg_s1 ^ quad[1];
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			neg_s2  <= neg2;
			spec_s2 <= spec_s1 || (rem == 27'd0);
			sval_s2 <= spec_s1 ? sval_s1 : (quad[0] ? {neg2, ONE_CODE} : 16'd0);
			r_s2    <= quad[0] ? 27'(HALF_PERIOD - {1'b0, rem}) : rem;
		end
	end

	// stages 3..8: linear path and Horner polynomial
	logic        neg_s3, spec_s3, lin_s3;
	logic [15:0] sval_s3;
	logic [36:0] linp_s3;
	logic [15:0] t_s3;
	logic [31:0] tt_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			neg_s3  <= neg_s2;
			spec_s3 <= spec_s2;
			sval_s3 <= sval_s2;
			lin_s3  <= r_s2 < LIN_LIMIT;
			linp_s3 <= r_s2[19:0] * LIN_SLOPE;
			t_s3    <= r_s2[26:11];
			tt_s3   <= r_s2[26:11] * r_s2[26:11];
		end
	end

	logic        neg_s4, spec_s4, lin_s4;
	logic [15:0] sval_s4;
	logic [21:0] lres_s4;
	logic [15:0] t_s4;
	logic [23:0] q_s4;
	logic [33:0] p1_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			neg_s4  <= neg_s3;
			spec_s4 <= spec_s3;
			sval_s4 <= sval_s3;
			lin_s4  <= lin_s3;
			lres_s4 <= linp_s3[36:15];
			t_s4    <= t_s3;
			q_s4    <= tt_s3[31:8];
			p1_s4   <= tt_s3[31:8] * POLY_C1;
		end
	end

	logic        neg_s5, spec_s5, lin_s5;
	logic [15:0] sval_s5;
	logic [21:0] lres_s5;
	logic [15:0] t_s5;
	logic [23:0] q_s5;
	logic [37:0] p2_s5;
	logic [13:0] c2;

	assign c2 = POLY_C2 - {5'd0, p1_s4[33:25]};

	always_ff @(posedge clk) begin
		if (en_s5) begin
			neg_s5  <= neg_s4;
			spec_s5 <= spec_s4;
			sval_s5 <= sval_s4;
			lin_s5  <= lin_s4;
			lres_s5 <= lres_s4;
			t_s5    <= t_s4;
			q_s5    <= q_s4;
			p2_s5   <= q_s4 * c2;
		end
	end

	logic        neg_s6, spec_s6, lin_s6;
	logic [15:0] sval_s6;
	logic [21:0] lres_s6;
	logic [15:0] t_s6;
	logic [23:0] q_s6;
	logic [42:0] p3_s6;
	logic [18:0] c3;

	assign c3 = POLY_C3 - {4'd0, p2_s5[37:23]};

	always_ff @(posedge clk) begin
		if (en_s6) begin
			neg_s6  <= neg_s5;
			spec_s6 <= spec_s5;
			sval_s6 <= sval_s5;
			lin_s6  <= lin_s5;
			lres_s6 <= lres_s5;
			t_s6    <= t_s5;
			q_s6    <= q_s5;
			p3_s6   <= q_s5 * c3;
		end
	end

	logic        neg_s7, spec_s7, lin_s7;
	logic [15:0] sval_s7;
	logic [21:0] lres_s7;
	logic [15:0] t_s7;
	logic [46:0] p4_s7;
	logic [22:0] c4;

	assign c4 = POLY_C4 - {3'd0, p3_s6[42:23]};

	always_ff @(posedge clk) begin
		if (en_s7) begin
			neg_s7  <= neg_s6;
			spec_s7 <= spec_s6;
			sval_s7 <= sval_s6;
			lin_s7  <= lin_s6;
			lres_s7 <= lres_s6;
			t_s7    <= t_s6;
			p4_s7   <= q_s6 * c4;
		end
	end

	logic        neg_s8, spec_s8, lin_s8;
	logic [15:0] sval_s8;
	logic [21:0] lres_s8;
	logic [41:0] p5_s8;
	logic [25:0] c5;

	assign c5 = POLY_C5 - {1'b0, p4_s7[46:22]};

	always_ff @(posedge clk) begin
		if (en_s8) begin
			neg_s8  <= neg_s7;
			spec_s8 <= spec_s7;
			sval_s8 <= sval_s7;
			lin_s8  <= lin_s7;
			lres_s8 <= lres_s7;
			p5_s8   <= t_s7 * c5;
		end
	end

	// stage 9: select, clamp, leading-one search
	logic [28:0] core;
	logic [27:0] fx28;
	logic        neg_s9, spec_s9;
	logic [15:0] sval_s9;
	logic [27:0] fx_s9;
	logic [4:0]  z_s9;

	always_comb begin
		core = lin_s8 ? {7'd0, lres_s8} : p5_s8[41:13];
		fx28 = (core > {1'b0, CORE_MAX}) ? CORE_MAX : core[27:0];
		if (fx28 == 28'd0) fx28 = 28'd1;
	end

	always_ff @(posedge clk) begin
		if (en_s9) begin
			neg_s9  <= neg_s8;
			spec_s9 <= spec_s8;
			sval_s9 <= sval_s8;
			fx_s9   <= fx28;
			z_s9    <= lzc28(fx28);
		end
	end

	// stage 10: normalize, regime scale
	logic [27:0] fn;
	logic [4:0]  lz;
	logic        lsb;
	logic        neg_s10, spec_s10;
	logic [15:0] sval_s10;
	logic [28:0] fx29_s10;
	logic [4:0]  sc_s10;

	always_comb begin
		fn  = fx_s9 << z_s9;
		lz  = 5'(z_s9 + 5'd1);
		lsb = lz[0];
	end

	always_ff @(posedge clk) begin
		if (en_s10) begin
			neg_s10  <= neg_s9;
			spec_s10 <= spec_s9;
			sval_s10 <= sval_s9;
			fx29_s10 <= {1'b1, lsb & fn[27], fn[26:0]};
			sc_s10   <= 5'({1'b0, lz[4:1]} + 5'd14 + {4'd0, lsb});
		end
	end

	// stage 11: round to nearest even, sign, special select
	logic [4:0]  scm1;
	logic [28:0] low_msk;
	logic [15:0] trunc;
	logic        rnd, sticky, inc;
	logic [15:0] rmag;
	logic [15:0] res_s11;

	always_comb begin
		scm1    = sc_s10 - 5'd1;
		low_msk = (29'd1 << scm1) - 29'd1;
		trunc   = 16'(fx29_s10 >> sc_s10);
		rnd     = fx29_s10[scm1];
		sticky  = |(fx29_s10 & low_msk);
		inc     = rnd && (sticky || trunc[0]);
		rmag    = 16'(trunc + {15'd0, inc});
	end

	always_ff @(posedge clk) begin
		if (en_s11) begin
			res_s11 <= spec_s10 ? sval_s10
			                    : (neg_s10 ? 16'(17'h1_0000 - {1'b0, rmag}) : rmag);
		end
	end

	assign res.valid     = v_s11;
	assign res.posit_out = res_s11;

	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!arg.ready |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && v_s7 && v_s8
		                && v_s9 && v_s10 && v_s11 && !res.ready))
		else $error("input stalled with a bubble in the pipeline");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !en_s6) |=> (v_s5 && $stable(p2_s5) && $stable(q_s5)))
		else $error("stalled Horner stage lost its item");

	a_nonzero_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !spec_s2) |-> (r_s2 != 27'd0))
		else $error("zero remainder reached the polynomial");

	a_scale_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s10 |-> (sc_s10 >= 5'd15 && sc_s10 <= 5'd28))
		else $error("rounding scale out of range");

endmodule

FILE: dv/tb_posit16_sinpi_fixed_point.sv
// Testbench for the posit16 sin(pi*x) pipeline: a queue-fed driver, a random-stall sink,
// and a scoreboard checked against a bit-exact fixed-point predictor.
// Depends on ps16s_pkg, the ps16s_in_if/ps16s_out_if channels and posit16_sinpi_fixed_point.
module tb_posit16_sinpi_fixed_point
	import ps16s_pkg::*;
();

	localparam int LATENCY     = 11;
	localparam int STUCK_LIMIT = 2000;
	localparam int CHUNK_ITEMS = 300;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	ps16s_in_if  arg_if ();
	ps16s_out_if res_if ();

	posit16_sinpi_fixed_point DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.arg    (arg_if),
		.res    (res_if)
	);

	always #1 clk = ~clk;

	logic [15:0] pending_args[$];
	logic [15:0] expected_results[$];
	logic [15:0] want;
	int          items_taken;
	int          taken_seen;
	int          results_seen;
	int          error_count;
	int          stuck_cycles;
	int          hold_left;
	bit          hold_done;
	bit          steady;

	function automatic logic [15:0] sinpi_expected(input logic [15:0] x);
		logic [63:0] mag, fx, t, q, acc, half;
		logic [1:0]  quad;
		logic        neg;
		int          sc, lz, lsb;
		neg = x[15];
		mag = neg ? ((64'h10000 - 64'(x)) & 64'h1FFFF) : 64'(x);
		if (mag > 64'(MAG_MAX))
			return (mag == 64'(NAR_CODE)) ? NAR_CODE : 16'h0000;
		if (mag == 64'd0)
			return 16'h0000;
		if (mag[14]) begin
			sc = 16;
			for (int i = 0; i < 16 && mag[13]; i++) begin
				mag = mag << 1;
				sc += 2;
			end
		end else begin
			sc = 14;
			for (int i = 0; i < 16 && !mag[13]; i++) begin
				mag = mag << 1;
				sc -= 2;
			end
		end
		if (mag[12])
			sc++;
		fx = (mag & 64'h0FFF) | 64'h1000;
		if (sc < 0)
			fx = (sc < -63) ? 64'd0 : (fx >> (-sc));
		else
			fx = (sc > 40) ? 64'd0 : (fx << sc);
		fx   = fx & 64'h1FFF_FFFF;
		quad = fx[28:27];
		fx   = fx & 64'h7FF_FFFF;
		if (quad[1])
			neg = ~neg;
		if (fx == 64'd0)
			return quad[0] ? {neg, ONE_CODE} : 16'h0000;
		if (quad[0])
			fx = 64'(HALF_PERIOD) - fx;
		if (fx < 64'(LIN_LIMIT)) begin
			fx = (fx * 64'(LIN_SLOPE)) >> 15;
		end else begin
			t   = fx >> 11;
			q   = (t * t) >> 8;
			acc = (q * 64'(POLY_C1)) >> 25;
			acc = (q * (64'(POLY_C2) - acc)) >> 23;
			acc = (q * (64'(POLY_C3) - acc)) >> 23;
			acc = (q * (64'(POLY_C4) - acc)) >> 22;
			fx  = (t * (64'(POLY_C5) - acc)) >> 13;
		end
		if (fx > 64'(CORE_MAX))
			fx = 64'(CORE_MAX);
		if (fx == 64'd0)
			fx = 64'd1;
		lz = 1;
		for (int i = 0; i < 28 && !fx[27]; i++) begin
			fx = fx << 1;
			lz++;
		end
		lsb = lz & 1;
		sc  = (lz >> 1) + 14 + lsb;
		if (lsb == 0)
			fx = fx & 64'h7FF_FFFF;
		fx   = fx | 64'h1000_0000;
		half = 64'd1 << (sc - 1);
		if ((fx & half) != 64'd0) begin
			if (((fx & (half - 64'd1)) != 64'd0) || ((fx & (half << 1)) != 64'd0))
				fx = fx + half;
		end
		fx = fx >> sc;
		return neg ? 16'(64'h10000 - fx) : 16'(fx);
	endfunction

	function automatic logic [15:0] draw_arg();
		logic [15:0] v;
		int          pick;
		pick = $urandom_range(99);
		if (pick < 60)
			v = 16'($urandom);
		else if (pick < 85)
			v = 16'($urandom_range(1, 16'h1800));
		else
			v = 16'(($urandom & 32'h7F00) + $urandom_range(2)) - 16'd1;
		if ($urandom_range(1) == 1)
			v = ~v + 16'd1;
		return v;
	endfunction

	task automatic wait_drained();
		while (pending_args.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
	endtask

	assign steady = (items_taken >= 350) && (items_taken < 470);

	always @(negedge clk) begin
		if (!arst_n) begin
			arg_if.valid <= 1'b0;
		end else if (!arg_if.valid || items_taken != taken_seen) begin
			taken_seen = items_taken;
			if (pending_args.size() != 0 && (steady || $urandom_range(99) >= 18)) begin
				arg_if.valid    <= 1'b1;
				arg_if.posit_in <= pending_args[0];
			end else begin
				arg_if.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else if (hold_left > 0) begin
			res_if.ready <= 1'b0;
			hold_left    <= hold_left - 1;
		end else if (!hold_done && results_seen >= 150) begin
			hold_done    <= 1'b1;
			hold_left    <= 80;
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= steady || ($urandom_range(99) >= 18);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (arg_if.valid && arg_if.ready) begin
				expected_results.push_back(sinpi_expected(arg_if.posit_in));
				void'(pending_args.pop_front());
				items_taken++;
			end
			if (res_if.valid && res_if.ready) begin
				if (expected_results.size() == 0) begin
					$error("posit_out: expected none, actual %h", res_if.posit_out);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					if (res_if.posit_out !== want) begin
						$error("posit_out: expected %h, actual %h", want, res_if.posit_out);
						error_count++;
					end
				end
				results_seen++;
			end
			if ((arg_if.valid && arg_if.ready) || (res_if.valid && res_if.ready))
				stuck_cycles = 0;
			else if (pending_args.size() != 0 || expected_results.size() != 0)
				stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		arg_if.valid    = 1'b0;
		arg_if.posit_in = 16'h0000;
		res_if.ready    = 1'b0;
		hold_left       = 0;
		hold_done       = 1'b0;
		items_taken     = 0;
		taken_seen      = 0;
		results_seen    = 0;
		error_count     = 0;
		stuck_cycles    = 0;
		pending_args = '{16'h0000, 16'h8000, 16'h0001, 16'hFFFF, 16'h7FFF,
			16'h8001, 16'h7BFF, 16'h7C00, 16'h8401, 16'h4000,
			16'h3800, 16'hC800, 16'h4800, 16'hB800, 16'h5800,
			16'h3000, 16'h3400, 16'h0100, 16'h0800, 16'h1000,
			16'h3FFF, 16'h4001, 16'h37FF, 16'h3801, 16'h6000};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		wait_drained();
		repeat (CHUNK_ITEMS) pending_args.push_back(draw_arg());
		wait_drained();
		repeat (CHUNK_ITEMS) pending_args.push_back(draw_arg());
		wait_drained();
		repeat (2 * LATENCY) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
